@@ hdl/assert_macros.svh @@
// assertion macros used by the rtl top level
// expects a clock named clk_i and an active-low reset named rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/ijs_pkg.sv @@
// shared constants, sequencer states and control struct of the interval jitter monitor
// no dependencies
package ijs_pkg;

  localparam int TS_BITS_DEF    = 64;
  localparam int COUNT_BITS_DEF = 21;
  localparam int CFG_BITS       = 21;
  localparam int CFG_RESET      = 1000;
  localparam int IN_BITS        = 64;
  localparam int OUT_FIELD_BITS = 55;
  localparam int OUT_DATA_BITS  = 224;
  localparam int SUM_BITS       = 64;
  localparam int NS_PER_US      = 1000;
  localparam int REM_BITS       = 10;
  localparam int CTR_BITS       = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_DIV,
    ST_UPD,
    ST_CHECK,
    ST_MEAN,
    ST_EMIT
  } ijs_state_e;

  typedef struct packed {
    logic arm;
    logic load;
    logic sub;
    logic div;
    logic upd;
    logic upd_narrow;
    logic upd_done;
    logic mean_load;
    logic mean_step;
  } ijs_ctrl_t;

endpackage

@@ hdl/ijs_interval.sv @@
// bit-serial interval unit: timestamp difference lsb first, then division by 1000 msb first
// depends on ijs_pkg
module ijs_interval import ijs_pkg::*; #(
  parameter int TIMESTAMP_BITS = TS_BITS_DEF,
  parameter int US_BITS        = TS_BITS_DEF - 9
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ijs_ctrl_t                 ctrl_i,
  input  logic [TIMESTAMP_BITS-1:0] ts_i,
  output logic [US_BITS-1:0]        us_o
);

  logic [TIMESTAMP_BITS-1:0] prev_q, work_q;
  logic [REM_BITS-1:0]       rem_q, rem_d;
  logic [US_BITS-1:0]        us_q;
  logic                      borrow_q;
  logic                      a_bit, b_bit, d_bit, borrow_d;
  logic [REM_BITS:0]         trial, trial_sub;
  logic                      ge;

  // serial subtract: work - prev
  assign a_bit    = work_q[0];
  assign b_bit    = prev_q[0];
  assign d_bit    = a_bit ^ b_bit ^ borrow_q;
  assign borrow_d = (~a_bit & b_bit) | (~(a_bit ^ b_bit) & borrow_q);

  // restoring division by the ns-per-us constant
  assign trial     = {rem_q, work_q[TIMESTAMP_BITS-1]};
  assign ge        = trial >= (REM_BITS+1)'(NS_PER_US);
  assign trial_sub = trial - (REM_BITS+1)'(NS_PER_US);
  assign rem_d     = ge ? trial_sub[REM_BITS-1:0] : trial[REM_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      borrow_q <= 1'b0;
      rem_q    <= '0;
    end else if (ctrl_i.load) begin
      borrow_q <= 1'b0;
      rem_q    <= '0;
    end else begin
      if (ctrl_i.sub) borrow_q <= borrow_d;
      if (ctrl_i.div) rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.arm) begin
      prev_q <= ts_i;
    end else if (ctrl_i.load) begin
      work_q <= ts_i;
    end else if (ctrl_i.sub) begin
      // the new timestamp replaces the old one as it streams out
      work_q <= {d_bit, work_q[TIMESTAMP_BITS-1:1]};
      prev_q <= {a_bit, prev_q[TIMESTAMP_BITS-1:1]};
    end else if (ctrl_i.div) begin
      work_q <= {work_q[TIMESTAMP_BITS-2:0], 1'b0};
      us_q   <= {us_q[US_BITS-2:0], ge};
    end else if (ctrl_i.upd_narrow) begin
      us_q   <= {us_q[0], us_q[US_BITS-1:1]};
    end
  end

  assign us_o = us_q;

endmodule

@@ hdl/ijs_stats.sv @@
// bit-serial window statistics: min, max, all-time max compares and saturating sum
// depends on ijs_pkg
module ijs_stats import ijs_pkg::*; #(
  parameter int US_BITS = TS_BITS_DEF - 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ijs_ctrl_t           ctrl_i,
  input  logic [US_BITS-1:0]  us_i,
  output logic [US_BITS-1:0]  min_o,
  output logic [US_BITS-1:0]  max_o,
  output logic [US_BITS-1:0]  max_ever_o,
  output logic [SUM_BITS-1:0] sum_o
);

  logic [US_BITS-1:0]  min_q, max_q, ever_q;
  logic [SUM_BITS-1:0] sum_q;
  logic                min_valid_q, lt_min_q, gt_max_q, gt_ever_q, carry_q;
  logic                u_bit, s_bit, sum_bit, carry_d;

  assign u_bit   = ctrl_i.upd_narrow & us_i[0];
  assign s_bit   = sum_q[0];
  assign sum_bit = u_bit ^ s_bit ^ carry_q;
  assign carry_d = (u_bit & s_bit) | (carry_q & (u_bit ^ s_bit));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_valid_q <= 1'b0;
      ever_q      <= '0;
      lt_min_q    <= 1'b0;
      gt_max_q    <= 1'b0;
      gt_ever_q   <= 1'b0;
      carry_q     <= 1'b0;
    end else if (ctrl_i.arm) begin
      min_valid_q <= 1'b0;
    end else if (ctrl_i.load) begin
      lt_min_q  <= 1'b0;
      gt_max_q  <= 1'b0;
      gt_ever_q <= 1'b0;
      carry_q   <= 1'b0;
    end else if (ctrl_i.upd_done) begin
      min_valid_q <= 1'b1;
      if (gt_ever_q) ever_q <= us_i;
    end else begin
      if (ctrl_i.upd) carry_q <= carry_d;
      if (ctrl_i.upd_narrow) begin
        // lsb-first compare: the highest differing bit decides last
        if (us_i[0] != min_q[0]) lt_min_q  <= ~us_i[0];
        if (us_i[0] != max_q[0]) gt_max_q  <= us_i[0];
        if (us_i[0] != ever_q[0]) gt_ever_q <= us_i[0];
        ever_q <= {ever_q[0], ever_q[US_BITS-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.arm) begin
      min_q <= '0;
      max_q <= '0;
      sum_q <= '0;
    end else if (ctrl_i.upd_done) begin
      if (!min_valid_q || lt_min_q) min_q <= us_i;
      if (gt_max_q) max_q <= us_i;
      sum_q <= sum_o;
    end else begin
      if (ctrl_i.upd) sum_q <= {sum_bit, sum_q[SUM_BITS-1:1]};
      if (ctrl_i.upd_narrow) begin
        min_q <= {min_q[0], min_q[US_BITS-1:1]};
        max_q <= {max_q[0], max_q[US_BITS-1:1]};
      end
    end
  end

  // carry out of the top bit saturates the sum
  assign sum_o      = carry_q ? '1 : sum_q;
  assign min_o      = min_q;
  assign max_o      = max_q;
  assign max_ever_o = ever_q;

endmodule

@@ hdl/ijs_mean_div.sv @@
// bit-serial restoring divider for the window mean, one quotient bit per cycle
// depends on ijs_pkg
module ijs_mean_div import ijs_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ijs_ctrl_t                 ctrl_i,
  input  logic [SUM_BITS-1:0]       sum_i,
  input  logic [COUNT_BITS-1:0]     divisor_i,
  output logic [OUT_FIELD_BITS-1:0] mean_o
);

  logic [SUM_BITS-1:0]   quo_q;
  logic [COUNT_BITS-1:0] rem_q;
  logic [COUNT_BITS:0]   trial, trial_sub;
  logic                  ge, hi;

  assign trial     = {rem_q, quo_q[SUM_BITS-1]};
  assign ge        = trial >= {1'b0, divisor_i};
  assign trial_sub = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (ctrl_i.mean_load) begin
      rem_q <= '0;
    end else if (ctrl_i.mean_step) begin
      rem_q <= ge ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mean_load) begin
      quo_q <= sum_i;
    end else if (ctrl_i.mean_step) begin
      quo_q <= {quo_q[SUM_BITS-2:0], ge};
    end
  end

  assign hi     = |quo_q[SUM_BITS-1:OUT_FIELD_BITS];
  assign mean_o = hi ? '1 : quo_q[OUT_FIELD_BITS-1:0];

endmodule

@@ hdl/interval_jitter_statistics.sv @@
// interval jitter monitor top level: sequencer, window count register, result register
// depends on ijs_pkg, ijs_interval, ijs_stats, ijs_mean_div, assert_macros.svh
//
//  channel   direction  handshake                        word
//  s_axis    in         s_axis_tvalid / s_axis_tready    timestamp_ns
//  m_axis    out        m_axis_tvalid / m_axis_tready    min, mean, max, max_ever
//  cfg       in         cfg_valid_i / cfg_ready_o        window_count
//
// the first event of a window only arms it; every other event runs a serial subtract,
// a divide by 1000 and a stats pass before the block takes the next event
// the event that closes a window adds a serial mean division and a result load
// reset clears the sequencer and sets window_count to 1000; no clearing pass
// a waiting result does not block the next event, only the next result load
`include "assert_macros.svh"

module interval_jitter_statistics import ijs_pkg::*; #(
  parameter int TIMESTAMP_BITS = TS_BITS_DEF,
  parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_BITS-1:0]       s_axis_tdata,   // [63:0] timestamp_ns
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // min_us, mean_us, max_us, max_ever_us, 55 b each
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_BITS-1:0]      cfg_data_i
);

  localparam int US_BITS = TIMESTAMP_BITS - 9;

  ijs_state_e                 state_q, state_d;
  logic [CTR_BITS-1:0]        cnt_q, cnt_d;
  logic                       armed_q, armed_d;
  logic [COUNT_BITS-1:0]      icount_q, icount_d, icount_inc;
  logic [CFG_BITS-1:0]        wcount_q;
  logic                       out_valid_q, out_valid_d, out_load;
  logic [OUT_DATA_BITS-1:0]   out_data_q;
  ijs_ctrl_t                  ctrl;

  logic [COUNT_BITS+CFG_BITS-1:0] wc_wide;
  logic [COUNT_BITS-1:0]          wc_cut, limit;
  logic [US_BITS-1:0]             us, min_v, max_v, ever_v;
  logic [SUM_BITS-1:0]            sum;
  logic [OUT_FIELD_BITS-1:0]      mean_v;
  logic                           in_fire, last_step;

  // window count reduced to COUNT_BITS; zero acts as one
  assign wc_wide    = {{COUNT_BITS{1'b0}}, wcount_q};
  assign wc_cut     = wc_wide[COUNT_BITS-1:0];
  assign limit      = (wc_cut == '0) ? COUNT_BITS'(1) : wc_cut;
  assign icount_inc = (icount_q == '1) ? icount_q : icount_q + COUNT_BITS'(1);

  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcount_q <= CFG_BITS'(CFG_RESET);
    end else if (cfg_valid_i) begin
      wcount_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      armed_q     <= 1'b0;
      icount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      armed_q     <= armed_d;
      icount_q    <= icount_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    armed_d   = armed_q;
    icount_d  = icount_q;
    out_load  = 1'b0;
    ctrl      = '0;
    last_step = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!armed_q) begin
            ctrl.arm = 1'b1;
            armed_d  = 1'b1;
            icount_d = '0;
          end else begin
            ctrl.load = 1'b1;
            cnt_d     = '0;
            state_d   = ST_SUB;
          end
        end
      end
      ST_SUB: begin
        ctrl.sub  = 1'b1;
        last_step = (cnt_q == CTR_BITS'(TIMESTAMP_BITS - 1));
        cnt_d     = last_step ? '0 : cnt_q + CTR_BITS'(1);
        if (last_step) state_d = ST_DIV;
      end
      ST_DIV: begin
        ctrl.div  = 1'b1;
        last_step = (cnt_q == CTR_BITS'(TIMESTAMP_BITS - 1));
        cnt_d     = last_step ? '0 : cnt_q + CTR_BITS'(1);
        if (last_step) state_d = ST_UPD;
      end
      ST_UPD: begin
        ctrl.upd        = 1'b1;
        ctrl.upd_narrow = (cnt_q < CTR_BITS'(US_BITS));
        last_step       = (cnt_q == CTR_BITS'(SUM_BITS - 1));
        cnt_d           = last_step ? '0 : cnt_q + CTR_BITS'(1);
        if (last_step) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        ctrl.upd_done = 1'b1;
        icount_d      = icount_inc;
        if (icount_inc >= limit) begin
          ctrl.mean_load = 1'b1;
          armed_d        = 1'b0;
          icount_d       = '0;
          cnt_d          = '0;
          state_d        = ST_MEAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MEAN: begin
        ctrl.mean_step = 1'b1;
        last_step      = (cnt_q == CTR_BITS'(SUM_BITS - 1));
        cnt_d          = last_step ? '0 : cnt_q + CTR_BITS'(1);
        if (last_step) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // wait until the result register is free
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {{(OUT_DATA_BITS - 4*OUT_FIELD_BITS){1'b0}},
                     OUT_FIELD_BITS'(ever_v), OUT_FIELD_BITS'(max_v),
                     mean_v, OUT_FIELD_BITS'(min_v)};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  ijs_interval #(
    .TIMESTAMP_BITS (TIMESTAMP_BITS),
    .US_BITS        (US_BITS)
  ) u_interval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .ts_i   (s_axis_tdata[TIMESTAMP_BITS-1:0]),
    .us_o   (us)
  );

  ijs_stats #(
    .US_BITS (US_BITS)
  ) u_stats (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .us_i       (us),
    .min_o      (min_v),
    .max_o      (max_v),
    .max_ever_o (ever_v),
    .sum_o      (sum)
  );

  ijs_mean_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_mean_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .sum_i     (sum),
    .divisor_i (limit),
    .mean_o    (mean_v)
  );

  `ASSERT_CLK(a_result_from_emit, $rose(out_valid_q) |-> $past(state_q) == ST_EMIT, "result appeared outside emit")
  `ASSERT_CLK(a_emit_loads, (state_q == ST_EMIT && state_d == ST_IDLE) |=> out_valid_q, "emit left without a result")
  `ASSERT_ALWAYS(a_busy_armed, (state_q == ST_SUB || state_q == ST_DIV || state_q == ST_UPD) |-> armed_q, "interval work while disarmed")
  `ASSERT_ALWAYS(a_mean_disarmed, (state_q == ST_MEAN || state_q == ST_EMIT) |-> !armed_q, "window end left block armed")

endmodule

@@ tb/ijs_window_monitor.sv @@
// passive monitor for interval_jitter_statistics: follows the event, result and window count
// channels, keeps its own copy of the window statistics and compares every result word
// depends on ijs_pkg
`timescale 1ns / 1ps

module ijs_window_monitor
  import ijs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  input  logic                     s_axis_tready,
  input  logic [IN_BITS-1:0]       s_axis_tdata,   // [63:0] timestamp_ns
  input  logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // min_us, mean_us, max_us, max_ever_us
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_o,
  input  logic [CFG_BITS-1:0]      cfg_data_i,
  output int                       mismatch_count_o,
  output int                       reports_due_o
);

  // index 0 is min_us, then mean_us, max_us, max_ever_us, as they sit in tdata
  typedef logic [3:0][OUT_FIELD_BITS-1:0] jitter_report_t;

  localparam logic [SUM_BITS-1:0]       OUT_CEIL   = (64'd1 << OUT_FIELD_BITS) - 64'd1;
  localparam logic [COUNT_BITS_DEF-1:0] COUNT_CEIL = '1;
  localparam int                        SHOWN_MAX  = 10;

  string field_name [4] = '{"min_us", "mean_us", "max_us", "max_ever_us"};

  jitter_report_t             expected_reports[$];
  logic [CFG_BITS-1:0]        window_count;
  logic                       armed;
  logic [TS_BITS_DEF-1:0]     last_stamp;
  logic [COUNT_BITS_DEF-1:0]  intervals_taken;
  logic [SUM_BITS-1:0]        window_min;
  logic                       min_seen;
  logic [SUM_BITS-1:0]        window_max;
  logic [SUM_BITS-1:0]        window_sum;
  logic [SUM_BITS-1:0]        peak_us;
  int                         errors;

  function automatic void flag(input string what, input logic [OUT_FIELD_BITS-1:0] want,
                               input logic [OUT_FIELD_BITS-1:0] got);
    errors++;
    if (errors <= SHOWN_MAX) begin
      $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    end
  endfunction

  // one timer event: arm the window or fold one interval into it
  function automatic void fold_event(input logic [TS_BITS_DEF-1:0] stamp);
    logic [SUM_BITS-1:0]       us;
    logic [COUNT_BITS_DEF-1:0] limit;
    logic [SUM_BITS-1:0]       mean;
    jitter_report_t            report;
    if (!armed) begin
      armed      = 1'b1;
      last_stamp = stamp;
      intervals_taken = '0;
      window_min = '0;
      min_seen   = 1'b0;
      window_max = '0;
      window_sum = '0;
    end else begin
      us = (stamp - last_stamp) / NS_PER_US;
      last_stamp = stamp;
      if (!min_seen || us < window_min) begin
        window_min = us;
        min_seen   = 1'b1;
      end
      if (us > window_max) window_max = us;
      if (us > peak_us) peak_us = us;
      if (window_sum > ~us) window_sum = '1;
      else window_sum = window_sum + us;
      if (intervals_taken != COUNT_CEIL) intervals_taken++;
      limit = (window_count[COUNT_BITS_DEF-1:0] == '0) ? COUNT_BITS_DEF'(1)
                                                       : window_count[COUNT_BITS_DEF-1:0];
      if (intervals_taken >= limit) begin
        mean = window_sum / SUM_BITS'(limit);
        if (mean > OUT_CEIL) mean = OUT_CEIL;
        report[0] = window_min[OUT_FIELD_BITS-1:0];
        report[1] = mean[OUT_FIELD_BITS-1:0];
        report[2] = window_max[OUT_FIELD_BITS-1:0];
        report[3] = peak_us[OUT_FIELD_BITS-1:0];
        expected_reports.push_back(report);
        armed = 1'b0;
        intervals_taken = '0;
      end
    end
  endfunction

  function automatic void check_report(input logic [OUT_DATA_BITS-1:0] word);
    jitter_report_t want;
    jitter_report_t got;
    got = word[4*OUT_FIELD_BITS-1:0];
    if (expected_reports.size() == 0) begin
      flag("report with none outstanding", '0, '0);
    end else begin
      want = expected_reports.pop_front();
      for (int k = 0; k < 4; k++) begin
        if (got[k] !== want[k]) flag(field_name[k], want[k], got[k]);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_count    = CFG_BITS'(CFG_RESET);
      armed           = 1'b0;
      last_stamp      = '0;
      intervals_taken = '0;
      window_min      = '0;
      min_seen        = 1'b0;
      window_max      = '0;
      window_sum      = '0;
      peak_us         = '0;
      errors          = 0;
      expected_reports.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) window_count = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) fold_event(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_report(m_axis_tdata);
    end
    mismatch_count_o <= errors;
    reports_due_o    <= expected_reports.size();
  end

endmodule

@@ tb/tb_top.sv @@
// top of the interval_jitter_statistics testbench: clock, reset, event and window count stimulus
// depends on ijs_pkg, the block and ijs_window_monitor, which predicts and compares the results
`timescale 1ns / 1ps

module tb_top;
  import ijs_pkg::*;

  localparam int DRAIN_CYCLES = 300;    // one closing event plus margin
  localparam int STALL_LIMIT  = 20000;
  localparam int PHASE_ITEMS  = 290;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_BITS-1:0]       s_axis_tdata  = '0;   // [63:0] timestamp_ns
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;         // min, mean, max, max_ever, 55 b each
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_BITS-1:0]      cfg_data_i    = '0;

  int                       mismatches;
  int                       reports_due;
  int                       tx_idle_pct = 14;
  int                       rx_idle_pct = 75;
  int                       quiet_cycles = 0;
  logic [IN_BITS-1:0]       stamp_ns;

  interval_jitter_statistics dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  ijs_window_monitor window_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatches),
    .reports_due_o   (reports_due)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // valid stays high between back-to-back words and only drops for a gap
  task automatic send_event(input logic [IN_BITS-1:0] stamp);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 400)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= stamp;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // a window may still be open with no result due, so let the block finish its pass
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (reports_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window_count(input logic [CFG_BITS-1:0] value);
    settle_block();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CFG_BITS-1:0] pick_window_count();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return CFG_BITS'(1);
    if (pick == 2) return CFG_BITS'($urandom_range(20, 40));
    return CFG_BITS'($urandom_range(1, 6));
  endfunction

  // mostly forward steps of realistic size, some huge, repeated or backwards
  function automatic logic [IN_BITS-1:0] next_stamp(input logic [IN_BITS-1:0] last);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return {$urandom, $urandom};
    if (pick < 60) return last + $urandom_range(0, 100000);
    if (pick < 80) return last + {32'd0, $urandom};
    if (pick < 88) return last + {24'd0, 8'($urandom_range(0, 255)), $urandom};
    if (pick < 92) return last;
    if (pick < 96) return last - $urandom_range(1, 5000);
    return last + {$urandom, $urandom};
  endfunction

  task automatic run_random(input int items);
    write_window_count(pick_window_count());
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 49) == 0) write_window_count(pick_window_count());
      stamp_ns = next_stamp(stamp_ns);
      send_event(stamp_ns);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset count of 1000 still in force, window stays open
    send_event(64'd0);
    send_event(64'd1500);
    send_event(64'd4700);
    // count lowered to the number of intervals already taken
    write_window_count(21'd2);
    send_event(64'd9999);
    // zero count behaves as one interval per window
    write_window_count('0);
    send_event(64'd0);
    send_event('1);
    send_event('1);
    send_event(64'd0);
    send_event(64'd1000);
    send_event(64'd999);
    send_event(64'hAAAA_AAAA_AAAA_AAAA);
    send_event(64'h5555_5555_5555_5555);
    // widest counts, then closed early by a small one
    write_window_count('1);
    send_event(64'd100);
    send_event(64'd2100);
    send_event(64'd5100);
    write_window_count(21'd2000000);
    send_event(64'd7100);
    write_window_count(21'd1);
    send_event(64'd8100);
    // equal stamps give zero intervals
    write_window_count(21'd3);
    repeat (4) send_event(64'h0123_4567_89AB_CDEF);
    stamp_ns = 64'h0123_4567_89AB_CDEF;

    run_random(PHASE_ITEMS);
    settle_block();
    tx_idle_pct = 75;
    rx_idle_pct = 14;
    run_random(PHASE_ITEMS);
    settle_block();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(PHASE_ITEMS);

    settle_block();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
